// ===== design/spbd_pkg.sv =====
// Package for the sprite pixel blend and dither core.
// Holds the blend mode codes, register indexes, dither patterns and shared types.
// No dependencies.
package spbd_pkg;

    localparam int PIXEL_W = 32;
    localparam int MODE_W  = 4;
    localparam int COL_W   = 3;
    localparam int ROW_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [PIXEL_W-1:0]    pixel_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    // Blend mode codes.
    localparam mode_t MODE_OPAQUE  = 4'd0;
    localparam mode_t MODE_KEY     = 4'd1;
    localparam mode_t MODE_HALF    = 4'd2;
    localparam mode_t MODE_MASK    = 4'd3;
    localparam mode_t MODE_DITHER1 = 4'd4;
    localparam mode_t MODE_DITHER2 = 4'd5;
    localparam mode_t MODE_DITHER3 = 4'd6;
    localparam mode_t MODE_DITHER4 = 4'd7;
    localparam mode_t MODE_DITHER5 = 4'd8;

    // Configuration register indexes.
    localparam cfg_idx_t CFG_BLEND_MODE  = 3'd0;
    localparam cfg_idx_t CFG_FILL_COLOUR = 3'd1;
    localparam cfg_idx_t CFG_KEY_COLOUR  = 3'd2;
    localparam cfg_idx_t CFG_PHASE_X     = 3'd3;
    localparam cfg_idx_t CFG_PHASE_Y     = 3'd4;

    // Each byte lane is halved to seven bits; the top byte is dropped.
    localparam logic [23:0] HALF_MASK = 24'h7f7f7f;

    localparam pixel_t DITHER_SPARSE = 32'h44001100;
    localparam pixel_t DITHER_LIGHT  = 32'h55005500;
    localparam pixel_t DITHER_CHECK  = 32'h55aa55aa;

    // Dither position: bit index is col + 8 * row.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } pos_t;

    // The five 8x4 ordered-dither patterns, from sparse to dense.
    function automatic pixel_t dither_pattern(input logic [2:0] idx);
        pixel_t pat;
        begin
            case (idx)
                3'd0:    pat = DITHER_SPARSE;
                3'd1:    pat = DITHER_LIGHT;
                3'd2:    pat = DITHER_CHECK;
                3'd3:    pat = ~DITHER_LIGHT;
                3'd4:    pat = ~DITHER_SPARSE;
                default: pat = DITHER_SPARSE;
            endcase
            return pat;
        end
    endfunction

endpackage

// ===== design/spbd_in_if.sv =====
// Input channel of the sprite pixel blend and dither core: one pixel pair a word.
// Depends on spbd_pkg.
interface spbd_in_if;
    logic                 valid;
    logic                 ready;
    spbd_pkg::pixel_t     source_pixel;
    spbd_pkg::pixel_t     dest_pixel;
    logic                 row_last;
    logic                 sprite_last;

    modport source (output valid, output source_pixel, output dest_pixel,
                    output row_last, output sprite_last, input ready);
    modport sink   (input valid, input source_pixel, input dest_pixel,
                    input row_last, input sprite_last, output ready);
endinterface

// ===== design/spbd_out_if.sv =====
// Output channel of the sprite pixel blend and dither core: one blended pixel a word.
// Depends on spbd_pkg.
interface spbd_out_if;
    logic             valid;
    logic             ready;
    spbd_pkg::pixel_t out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

// ===== design/spbd_position.sv =====
// Dither position counters: column and row phase within the sprite.
// Depends on spbd_pkg.
module spbd_position
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          row_last,
    input  logic          sprite_last,
    output spbd_pkg::pos_t pos
);

    logic [spbd_pkg::COL_W-1:0] column_phase_reg;
    logic [spbd_pkg::COL_W-1:0] column_phase_next;
    logic [spbd_pkg::ROW_W-1:0] row_phase_reg;
    logic [spbd_pkg::ROW_W-1:0] row_phase_next;

    always_comb
    begin
        column_phase_next = column_phase_reg;
        row_phase_next    = row_phase_reg;
        if (advance)
        begin
            if (sprite_last)
            begin
                column_phase_next = '0;
                row_phase_next    = '0;
            end
            else if (row_last)
            begin
                column_phase_next = '0;
                row_phase_next    = row_phase_reg + 1'b1;
            end
            else
            begin
                column_phase_next = column_phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_phase_reg <= '0;
            row_phase_reg    <= '0;
        end
        else
        begin
            column_phase_reg <= column_phase_next;
            row_phase_reg    <= row_phase_next;
        end
    end

    assign pos.col = column_phase_reg;
    assign pos.row = row_phase_reg;

endmodule

// ===== design/spbd_blend.sv =====
// Blend datapath: picks the output pixel for one pixel pair under the current mode.
// Depends on spbd_pkg.
module spbd_blend
(
    input  spbd_pkg::mode_t  mode,
    input  spbd_pkg::pixel_t fill_colour,
    input  spbd_pkg::pixel_t key_colour,
    input  spbd_pkg::pixel_t source_pixel,
    input  spbd_pkg::pixel_t dest_pixel,
    input  spbd_pkg::pos_t   pos,
    output spbd_pkg::pixel_t out_pixel
);

    logic              keyed;
    logic [23:0]       half_sum;
    spbd_pkg::mode_t   pat_sel;
    spbd_pkg::pixel_t  pattern;
    logic              pat_on;

    assign keyed = (source_pixel == key_colour);

    // Each lane is at most 0x7f, so the lane sums never carry into a neighbor.
    assign half_sum = (source_pixel[24:1] & spbd_pkg::HALF_MASK)
                    + (dest_pixel[24:1] & spbd_pkg::HALF_MASK);

    assign pat_sel = mode - spbd_pkg::MODE_DITHER1;
    assign pattern = spbd_pkg::dither_pattern(pat_sel[2:0]);
    assign pat_on  = pattern[pos];

    always_comb
    begin
        case (mode)
            spbd_pkg::MODE_KEY:
                out_pixel = keyed ? dest_pixel : source_pixel;
            spbd_pkg::MODE_HALF:
                out_pixel = keyed ? dest_pixel : {8'd0, half_sum};
            spbd_pkg::MODE_MASK:
                out_pixel = keyed ? dest_pixel : fill_colour;
            spbd_pkg::MODE_DITHER1, spbd_pkg::MODE_DITHER2, spbd_pkg::MODE_DITHER3,
            spbd_pkg::MODE_DITHER4, spbd_pkg::MODE_DITHER5:
                out_pixel = (keyed || !pat_on) ? dest_pixel : source_pixel;
            default:
                out_pixel = source_pixel;
        endcase
    end

endmodule

// ===== design/sprite_pixel_blend_dither_core.sv =====
// Top level of the sprite pixel blend and dither core.
// Depends on spbd_pkg, spbd_in_if, spbd_out_if, spbd_position and spbd_blend.
//
// Usage:
// Pixel pairs enter on pix_in in raster order, one word per pair: the sprite
// pixel, the framebuffer pixel beneath it, and row-end and sprite-end marks.
// Each word gives exactly one blended pixel word on pix_out, in order.
// The blend is chosen by five registers written through cfg_we, cfg_index and
// cfg_wdata; write them only while no pixel is in flight.
// An input register captures the pair and its dither position, and the blend
// logic works between it and the output register. A new word is accepted every
// cycle while the receiver takes words. When the receiver stalls, the output
// register holds its word and the input register fills; pix_in.ready drops
// only when both are full, so no word is lost or repeated and full rate resumes
// as soon as the receiver takes a word.
// Reset clears both pipeline stages, the dither counters and all registers
// (mode opaque, colours zero, phases zero).
// The dither column counter wraps every 8 pixels, the row counter every 4 rows;
// the sprite-end mark clears both and takes priority over the row-end mark.
module sprite_pixel_blend_dither_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  spbd_pkg::cfg_idx_t             cfg_index,
    input  logic [spbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    spbd_in_if.sink                        pix_in,
    spbd_out_if.source                     pix_out
);

    // Configuration registers.
    spbd_pkg::mode_t  blend_mode_reg;
    spbd_pkg::pixel_t fill_colour_reg;
    spbd_pkg::pixel_t key_colour_reg;
    logic             phase_x_reg;
    logic             phase_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg  <= spbd_pkg::MODE_OPAQUE;
            fill_colour_reg <= '0;
            key_colour_reg  <= '0;
            phase_x_reg     <= 1'b0;
            phase_y_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spbd_pkg::CFG_BLEND_MODE:  blend_mode_reg  <= cfg_wdata[spbd_pkg::MODE_W-1:0];
                spbd_pkg::CFG_FILL_COLOUR: fill_colour_reg <= cfg_wdata;
                spbd_pkg::CFG_KEY_COLOUR:  key_colour_reg  <= cfg_wdata;
                spbd_pkg::CFG_PHASE_X:     phase_x_reg     <= cfg_wdata[0];
                spbd_pkg::CFG_PHASE_Y:     phase_y_reg     <= cfg_wdata[0];
                default:                   ;
            endcase
        end
    end

    // Handshake control for the two pipeline stages.
    logic in_accept;
    logic s1_advance;
    logic s1_valid_reg;
    logic out_valid_reg;

    assign s1_advance   = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || s1_advance;
    assign in_accept    = pix_in.valid && pix_in.ready;

    // Dither position counters advance once per accepted word.
    spbd_pkg::pos_t raw_pos;

    spbd_position u_position
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (in_accept),
        .row_last    (pix_in.row_last),
        .sprite_last (pix_in.sprite_last),
        .pos         (raw_pos)
    );

    // The origin parities flip only the low bit of column and row.
    spbd_pkg::pos_t pos_in;

    assign pos_in.col = raw_pos.col ^ {{(spbd_pkg::COL_W-1){1'b0}}, phase_x_reg};
    assign pos_in.row = raw_pos.row ^ {{(spbd_pkg::ROW_W-1){1'b0}}, phase_y_reg};

    // Input register stage.
    spbd_pkg::pixel_t s1_src_reg;
    spbd_pkg::pixel_t s1_dst_reg;
    spbd_pkg::pos_t   s1_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            s1_valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_src_reg <= pix_in.source_pixel;
            s1_dst_reg <= pix_in.dest_pixel;
            s1_pos_reg <= pos_in;
        end
    end

    // Blend logic between the input and output registers.
    spbd_pkg::pixel_t blend_pixel;

    spbd_blend u_blend
    (
        .mode         (blend_mode_reg),
        .fill_colour  (fill_colour_reg),
        .key_colour   (key_colour_reg),
        .source_pixel (s1_src_reg),
        .dest_pixel   (s1_dst_reg),
        .pos          (s1_pos_reg),
        .out_pixel    (blend_pixel)
    );

    // Output register stage.
    spbd_pkg::pixel_t out_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pix_out.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_pixel_reg <= blend_pixel;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;

    // A word accepted at the input always lands in the input stage.
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted word did not reach the input stage");

    // A word leaving the input stage always lands in the output register.
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("input stage word did not reach the output register");

    // With both stages full and the receiver stalled, the input stage holds.
    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pix_out.ready)
            |=> (s1_valid_reg && $stable(s1_src_reg) && $stable(s1_dst_reg)))
        else $error("input stage changed while stalled");

    // The sprite-end mark clears both dither counters.
    a_sprite_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && pix_in.sprite_last) |=> (raw_pos.col == '0 && raw_pos.row == '0))
        else $error("sprite end did not clear the dither counters");

endmodule
